// ===== sv/wrpick_pkg.sv =====
package wrpick_pkg;

    localparam int POOL_ENTRIES = 16;
    localparam int PIDX_W       = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int DIV_STEPS    = 32;
    localparam int DCNT_W       = $clog2(DIV_STEPS);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PICK  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  entry_index;
        logic [15:0] entry_item;
        logic [15:0] entry_weight;
        logic [31:0] random_value;
    } t_pick_in;

    typedef struct packed {
        logic [15:0] chosen_item;
        logic        empty_pool;
    } t_pick_out;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [16:0] a;
        logic [15:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [16:0] res;
        logic        ge;
    } t_alu_rsp;

endpackage

// ===== sv/wrpick_alu.sv =====
module wrpick_alu
    import wrpick_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [17:0] w_diff;

    assign w_diff = {1'b0, i_req.a} - {2'b00, i_req.b};

    always_comb begin
        o_rsp.ge = ~w_diff[17];
        unique case (i_req.op)
            ALU_ADD: o_rsp.res = i_req.a + {1'b0, i_req.b};
            ALU_SUB: o_rsp.res = w_diff[16:0];
            default: o_rsp.res = '0;
        endcase
    end

endmodule

// ===== sv/weighted_random_pick_unit.sv =====
// Weighted random pick (roulette-wheel selection) over a small pool.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) carries commands:
//   cmd = write : fills one pool slot (item, weight) and produces no
//                 result item.
//   cmd = pick  : uses random_value to choose a slot by weight and returns
//                 one result item on the output channel.
// Output channel (o_out_valid / i_out_ready / o_out_item) carries
//   chosen_item and empty_pool (total weight zero, item 0).
//
// A pick accepts the command, totals the weights in S_SUM, runs a
// restoring modulo of the random word by the total in S_DIV, scans the
// slots in S_SCAN and loads the result in S_FIN. An empty pool skips
// modulo and scan. One shared add/subtract-compare unit sets the pace;
// o_in_ready is low while a pick is in work.
// The result sits in an output register; new items are taken while it
// waits, but a following pick stalls at its end until the register frees.
// Reset clears the pool (per-slot valid bits) and drops any pending result.
module weighted_random_pick_unit
    import wrpick_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_pick_in  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_pick_out o_out_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_SCAN,
        S_FIN
    } t_state;

    t_state r_state;

    // pool storage; a slot that was never written reads as zero
    logic [15:0]             r_items   [POOL_ENTRIES];
    logic [15:0]             r_weights [POOL_ENTRIES];
    logic [POOL_ENTRIES-1:0] r_valid;

    logic [PIDX_W-1:0] r_idx;     // slot walked by sum and scan
    logic [DCNT_W-1:0] r_dcnt;    // modulo step counter
    logic [31:0]       r_dvd;     // random word, shifted out MSB first
    logic [15:0]       r_sum;     // 16-bit wrapping total
    logic [15:0]       r_rem;     // modulo remainder, then scan remainder
    t_pick_out         r_res;
    logic              r_out_valid;
    t_pick_out         r_out_item;

    logic              w_in_acc;
    logic              w_wr_ok;
    logic [PIDX_W-1:0] w_wr_addr;
    logic [15:0]       w_rd_item;
    logic [15:0]       w_rd_weight;
    logic              w_last_idx;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_wr_ok     = (32'(i_in_item.entry_index) < POOL_ENTRIES);
    assign w_wr_addr   = PIDX_W'(i_in_item.entry_index);
    assign w_rd_item   = r_valid[r_idx] ? r_items[r_idx]   : 16'd0;
    assign w_rd_weight = r_valid[r_idx] ? r_weights[r_idx] : 16'd0;
    assign w_last_idx  = (r_idx == PIDX_W'(POOL_ENTRIES - 1));

    // operand steering for the shared unit
    always_comb begin
        w_alu_req.op = ALU_SUB;
        w_alu_req.a  = {1'b0, r_rem};
        w_alu_req.b  = w_rd_weight;
        unique case (r_state)
            S_SUM: begin
                w_alu_req.op = ALU_ADD;
                w_alu_req.a  = {1'b0, r_sum};
            end
            S_DIV: begin
                w_alu_req.a = {r_rem, r_dvd[31]};
                w_alu_req.b = r_sum;
            end
            default: begin
            end
        endcase
    end

    wrpick_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // slot data, no reset: r_valid masks unwritten slots
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in_item.cmd == CMD_WRITE && w_wr_ok) begin
            r_items[w_wr_addr]   <= i_in_item.entry_item;
            r_weights[w_wr_addr] <= i_in_item.entry_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_FIN reloads the register itself when the item leaves
            if (r_out_valid && i_out_ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_in_item.cmd == CMD_WRITE) begin
                            if (w_wr_ok) begin
                                r_valid[w_wr_addr] <= 1'b1;
                            end
                        end else begin
                            r_dvd   <= i_in_item.random_value;
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_SUM: begin
                    // total up to the first zero item
                    if (w_rd_item == 16'd0 || w_last_idx) begin
                        if (w_rd_item != 16'd0) begin
                            r_sum <= w_alu_rsp.res[15:0];
                        end
                        if (w_rd_item == 16'd0 && r_sum == 16'd0 ||
                            w_rd_item != 16'd0 && w_alu_rsp.res[15:0] == 16'd0) begin
                            r_res.chosen_item <= 16'd0;
                            r_res.empty_pool  <= 1'b1;
                            r_state           <= S_FIN;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_sum <= w_alu_rsp.res[15:0];
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DIV: begin
                    // restoring modulo, one dividend bit a cycle
                    r_rem <= w_alu_rsp.ge ? w_alu_rsp.res[15:0] : w_alu_req.a[15:0];
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_res.empty_pool <= 1'b0;
                    priority if (w_rd_item == 16'd0) begin
                        r_res.chosen_item <= 16'd0;
                        r_state           <= S_FIN;
                    end else if (!w_alu_rsp.ge) begin
                        r_res.chosen_item <= w_rd_item;
                        r_state           <= S_FIN;
                    end else begin
                        r_rem <= w_alu_rsp.res[15:0];
                        if (w_last_idx) begin
                            r_res.chosen_item <= 16'd0;
                            r_state           <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== sv/wrpick_chk.sv =====
module wrpick_chk
    import wrpick_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_pick_in  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_pick_out o_out_item
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // empty pool always returns item zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.empty_pool |-> o_out_item.chosen_item == 16'd0)
        else $error("empty pool with nonzero item");

    // a pick keeps the unit busy, so ready is low in the next cycle
    a_pick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.cmd == CMD_PICK |=> !o_in_ready)
        else $error("ready right after pick accept");

    // a write yields no result in the next cycle unless one was already pending
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_item.cmd == CMD_WRITE && !o_out_valid
        |=> !o_out_valid)
        else $error("write produced a result");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind weighted_random_pick_unit wrpick_chk u_wrpick_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== sim/weighted_random_pick_unit_tb.sv =====
`timescale 1ns / 100ps

module weighted_random_pick_unit_tb
    import wrpick_pkg::*;
();

    localparam int RAND_ITEMS  = 430;
    localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int TAIL_CYCLES = 120;   // longer than one full pick
    localparam int DIR_ROWS    = 23;

    // One directed row: command word, whether the result is written out here,
    // and that result. Pick rows without a typed result go through the pick predictor.
    typedef struct packed {
        t_pick_in  stim;
        logic      typed;
        t_pick_out want;
    } t_dir_row;

    typedef enum int {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_pick_in  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_pick_out out_item;

    // Shadow copy of the pool, updated when a write item is accepted
    logic [15:0] pool_item_m   [POOL_ENTRIES];
    logic [15:0] pool_weight_m [POOL_ENTRIES];

    t_pick_out pick_expect_q [$];

    int n_sent     = 0;
    int n_writes   = 0;
    int n_picks    = 0;
    int n_empty    = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int idle_count = 0;
    int burst_left = 0;

    t_rx_mode rx_mode = RX_STEADY;
    int       rx_left = 0;

    // Columns: cmd, index, item, weight, random word | typed, chosen, empty
    t_dir_row dir_tab [DIR_ROWS] = '{
        // nothing written yet: empty pool
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1, 16'h0000, 1'b1},
        {CMD_PICK,  4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 16'h0000, 1'b1},
        // one slot, zero weight: still empty
        {CMD_WRITE, 4'h0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h1234_5678, 1'b1, 16'h0000, 1'b1},
        // 1 + 0xFFFF wraps the 16-bit total to zero
        {CMD_WRITE, 4'h0, 16'h0001, 16'h0001, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_WRITE, 4'h1, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h7, 16'h1111, 16'h2222, 32'hDEAD_BEEF, 1'b1, 16'h0000, 1'b1},
        // total 0xFFFF, random word extremes
        {CMD_WRITE, 4'h1, 16'hAAAA, 16'hFFFE, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h0000_FFFE, 1'b0, 16'h0000, 1'b0},
        // wrapping sum that stays nonzero
        {CMD_WRITE, 4'h2, 16'h5555, 16'h8000, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h8000_0000, 1'b0, 16'h0000, 1'b0},
        // zero item in slot 1 ends the pool early
        {CMD_WRITE, 4'h1, 16'h0000, 16'h1234, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'hDEAD_BEEF, 1'b0, 16'h0000, 1'b0},
        {CMD_WRITE, 4'hF, 16'h8001, 16'h0005, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h0000_0007, 1'b0, 16'h0000, 1'b0},
        // zero-weight slot in the middle is skipped
        {CMD_WRITE, 4'h1, 16'h0002, 16'h0000, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h0000_0001, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, 16'h0000, 1'b0},
        {CMD_WRITE, 4'h3, 16'h7FFF, 16'hFFFF, 32'h0000_0000, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
        {CMD_PICK,  4'h0, 16'h0000, 16'h0000, 32'h0000_8000, 1'b0, 16'h0000, 1'b0}
    };

    weighted_random_pick_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------------
    // Pick predictor
    // ---------------------------------------------------------------------

    // Weight sum up to the first zero item, kept to 16 bits like the block
    function automatic logic [15:0] pool_total();
        logic [15:0] sum;
        sum = '0;
        for (int k = 0; k < POOL_ENTRIES; k++) begin
            if (pool_item_m[k] == '0)
                break;
            sum += pool_weight_m[k];
        end
        return sum;
    endfunction

    // Roulette walk: peel weights off the remainder until one covers it
    function automatic t_pick_out predict_pick(input logic [31:0] rnd);
        t_pick_out   res;
        logic [15:0] total;
        logic [31:0] rem;
        res   = '0;
        total = pool_total();
        if (total == '0) begin
            res.empty_pool = 1'b1;
            return res;
        end
        rem = rnd % {16'h0, total};
        for (int k = 0; k < POOL_ENTRIES; k++) begin
            if (pool_item_m[k] == '0)
                break;
            if (rem >= {16'h0, pool_weight_m[k]}) begin
                rem -= {16'h0, pool_weight_m[k]};
            end else begin
                res.chosen_item = pool_item_m[k];
                break;
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Fully random command word; callers override the fields they care about
    function automatic t_pick_in rand_word();
        t_pick_in c;
        c.cmd          = logic'($urandom_range(0, 1));
        c.entry_index  = 4'($urandom_range(0, 15));
        c.entry_item   = 16'($urandom_range(0, 65535));
        c.entry_weight = 16'($urandom_range(0, 65535));
        c.random_value = $urandom;
        return c;
    endfunction

    function automatic logic [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3, 4, 5: return 16'($urandom_range(1, 16));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] rand_item();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'h0001;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // Random word for a pick, aimed often at the modulo boundaries
    function automatic logic [31:0] pick_word();
        logic [31:0] total;
        total = {16'h0, pool_total()};
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return total * 32'($urandom_range(0, 65535)) + total - 32'd1;
            3:       return total * 32'($urandom_range(0, 65535));
            default: return $urandom;
        endcase
    endfunction

    // Present one item, hold it until accepted, then update the shadow pool
    // or queue the expected result. After the accepting edge it applies the
    // sender's burst/gap pacing, then returns.
    task automatic send_cmd(input t_pick_in c, input logic typed, input t_pick_out want);
        in_valid <= 1'b1;
        in_item  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        n_sent++;
        if (c.cmd == CMD_WRITE) begin
            n_writes++;
            if (int'(c.entry_index) < POOL_ENTRIES) begin
                pool_item_m[c.entry_index]   = c.entry_item;
                pool_weight_m[c.entry_index] = c.entry_weight;
            end
        end else begin
            n_picks++;
            pick_expect_q.push_back(typed ? want : predict_pick(c.random_value));
        end
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_pick();
        t_pick_in c;
        c              = rand_word();
        c.cmd          = CMD_PICK;
        c.random_value = pick_word();
        send_cmd(c, 1'b0, '0);
    endtask

    task automatic send_write(input int slot, input logic [15:0] itm, input logic [15:0] wgt);
        t_pick_in c;
        c              = rand_word();
        c.cmd          = CMD_WRITE;
        c.entry_index  = 4'(slot);
        c.entry_item   = itm;
        c.entry_weight = wgt;
        send_cmd(c, 1'b0, '0);
    endtask

    // Sender holds off until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pick_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Receiver: stall pattern switches between always-ready, coin-flip and
    // mostly-stalled stretches
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 2));
            rx_left <= $urandom_range(50, 400);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_STEADY: out_ready <= 1'b1;
            RX_RANDOM: out_ready <= logic'($urandom_range(0, 1));
            default:   out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------------
    always @(posedge clk) begin
        t_pick_out exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (pick_expect_q.size() == 0) begin
                $error("result item with none expected: chosen_item %h empty_pool %b",
                       out_item.chosen_item, out_item.empty_pool);
                n_errors++;
            end else begin
                exp_r = pick_expect_q.pop_front();
                n_checked++;
                if (exp_r.empty_pool)
                    n_empty++;
                if (out_item.chosen_item !== exp_r.chosen_item) begin
                    $error("chosen_item: expected %h, got %h",
                           exp_r.chosen_item, out_item.chosen_item);
                    n_errors++;
                end
                if (out_item.empty_pool !== exp_r.empty_pool) begin
                    $error("empty_pool: expected %b, got %b",
                           exp_r.empty_pool, out_item.empty_pool);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: no item moving on either channel for too long
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT) begin
            $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        int  n_slots;
        bit  drained_mid;
        for (int k = 0; k < POOL_ENTRIES; k++) begin
            pool_item_m[k]   = '0;
            pool_weight_m[k] = '0;
        end
        drained_mid = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (dir_tab[r])
            send_cmd(dir_tab[r].stim, dir_tab[r].typed, dir_tab[r].want);
        drain_results();

        // Random part. Mostly well-formed pools (nonzero items from slot 0
        // up, sometimes closed by a zero item) followed by a few picks, plus
        // small edits and raw noise.
        while (n_sent < DIR_ROWS + RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: begin
                    n_slots = ($urandom_range(0, 3) == 0) ? POOL_ENTRIES
                                                          : $urandom_range(1, 6);
                    for (int k = 0; k < n_slots; k++)
                        send_write(k, rand_item(), rand_weight());
                    if (n_slots < POOL_ENTRIES && $urandom_range(0, 1) == 1)
                        send_write(n_slots, 16'h0000, rand_weight());
                    repeat ($urandom_range(1, 6)) send_pick();
                end
                7, 8: begin
                    repeat ($urandom_range(1, 3))
                        send_write($urandom_range(0, POOL_ENTRIES - 1),
                                   ($urandom_range(0, 4) == 0) ? 16'h0000 : rand_item(),
                                   rand_weight());
                    repeat ($urandom_range(1, 4)) send_pick();
                end
                default: begin
                    repeat ($urandom_range(1, 6)) send_cmd(rand_word(), 1'b0, '0);
                end
            endcase
            if (!drained_mid && n_sent > DIR_ROWS + RAND_ITEMS / 2) begin
                drain_results();
                drained_mid = 1'b1;
            end
        end

        in_valid <= 1'b0;
        while (pick_expect_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items: %0d pool writes, %0d picks under varied pacing.",
                 n_sent, n_writes, n_picks);
        $display("Checked %0d results (%0d with an empty pool), %0d mismatches.",
                 n_checked, n_empty, n_errors);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
